>>> design/skc_pkg.sv
// Shared types, codes and reset constants for the setpoint key controller.
package skc_pkg;

   localparam int VALUE_BITS_DEF = 10;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;
   localparam int COUNT_BITS     = 8;

   localparam int MAX_VALUE_RESET      = 450;
   localparam int STEP_SIZE_RESET      = 5;
   localparam int LOCKOUT_TICKS_RESET  = 10;
   localparam int REPEAT_TICKS_RESET   = 3;
   localparam int TIMEOUT_SECS_RESET   = 5;

   typedef enum logic [2:0] {
      REG_MAX_VALUE     = 3'd0,
      REG_STEP_SIZE     = 3'd1,
      REG_LOCKOUT_TICKS = 3'd2,
      REG_REPEAT_TICKS  = 3'd3,
      REG_TIMEOUT_SECS  = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_KEY_SCAN    = 3'd0,
      OP_SECOND_TICK = 3'd1,
      OP_REPEAT_TICK = 3'd2,
      OP_OFF_REQUEST = 3'd3,
      OP_ATTACH      = 3'd4,
      OP_RESTORE     = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_SET    = 2'd1,
      MODE_NODEV  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      BEEP_NONE   = 2'd0,
      BEEP_SHORT  = 2'd1,
      BEEP_TRIPLE = 2'd2
   } beep_type;

   // Timing and step settings shared by the register file and the core
   typedef struct packed {
      logic [COUNT_BITS-1:0] step_size;
      logic [COUNT_BITS-1:0] lockout_ticks;
      logic [COUNT_BITS-1:0] repeat_ticks;
      logic [COUNT_BITS-1:0] timeout_secs;
   } cfg_type;

endpackage

>>> design/setpoint_key_controller.sv
// Top level: input register, channel core, result register and config port.
//
//   channel  ports   beat contents
//   -------  ------  ---------------------------------------------------------
//   event    req_*   tuser: op; tdata: keys, attached, restore_value
//   result   rsp_*   tdata: power_on, mode, target, edit_value, save, beep
//   config   csr_*   APB-style, five registers at byte address 4*index
//
// Each event moves from the input register through the state update into
// the result register, one beat per cycle while the result sink is ready.
// A stalled result register holds the input register, and req_tready drops
// only when both are full. Synchronous reset restores the valid flags, the
// configuration and the channel state, but not the beat data registers.
module setpoint_key_controller
   import skc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   localparam int REQ_USED = 4 + VALUE_BITS,
   localparam int REQ_BITS = ((REQ_USED + 7) / 8) * 8,
   localparam int RSP_USED = 6 + 2 * VALUE_BITS,
   localparam int RSP_BITS = ((RSP_USED + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // tdata: power_key, plus_key, minus_key, attached, restore_value
   input  logic [REQ_BITS-1:0]        req_tdata,
   // tuser: op
   input  logic [2:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // tdata: power_on, mode, target, edit_value, save_request, beep
   output logic [RSP_BITS-1:0]        rsp_tdata,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                       csr_pready
);

   logic                  in_valid_ff;
   op_type                op_ff;
   logic                  power_key_ff;
   logic                  plus_key_ff;
   logic                  minus_key_ff;
   logic                  attached_ff;
   logic [VALUE_BITS-1:0] restore_ff;
   logic                  advance;
   logic                  rsp_valid_ff;
   logic [RSP_BITS-1:0]   rsp_data_ff;
   logic [RSP_BITS-1:0]   rsp_data_in;

   logic [VALUE_BITS-1:0] max_value;
   cfg_type               cfg;
   logic                  power_on;
   mode_type              mode;
   logic [VALUE_BITS-1:0] target;
   logic [VALUE_BITS-1:0] edit_value;
   logic                  save_request;
   beep_type              beep;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         op_ff        <= op_type'(req_tuser);
         power_key_ff <= req_tdata[0];
         plus_key_ff  <= req_tdata[1];
         minus_key_ff <= req_tdata[2];
         attached_ff  <= req_tdata[3];
         restore_ff   <= req_tdata[4 +: VALUE_BITS];
      end
   end

   skc_csr #(
      .VALUE_BITS (VALUE_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .max_value (max_value),
      .cfg       (cfg)
   );

   skc_core #(
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .op            (op_ff),
      .power_key     (power_key_ff),
      .plus_key      (plus_key_ff),
      .minus_key     (minus_key_ff),
      .attached      (attached_ff),
      .restore_value (restore_ff),
      .max_value     (max_value),
      .cfg           (cfg),
      .power_on      (power_on),
      .mode          (mode),
      .target        (target),
      .edit_value    (edit_value),
      .save_request  (save_request),
      .beep          (beep)
   );

   assign rsp_data_in = RSP_BITS'({beep, save_request, edit_value, target, mode, power_on});

   // hold the result beat until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> design/skc_csr.sv
// Configuration register file behind the APB-style port.
module skc_csr
   import skc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [VALUE_BITS-1:0]    max_value,
   output cfg_type                  cfg
);

   logic [VALUE_BITS-1:0] max_value_ff;
   cfg_type               cfg_ff;
   logic                  wr_en;
   reg_index_type         index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff         <= VALUE_BITS'(MAX_VALUE_RESET);
         cfg_ff.step_size     <= COUNT_BITS'(STEP_SIZE_RESET);
         cfg_ff.lockout_ticks <= COUNT_BITS'(LOCKOUT_TICKS_RESET);
         cfg_ff.repeat_ticks  <= COUNT_BITS'(REPEAT_TICKS_RESET);
         cfg_ff.timeout_secs  <= COUNT_BITS'(TIMEOUT_SECS_RESET);
      end else if (wr_en) begin
         unique case (index)
            REG_MAX_VALUE:     max_value_ff         <= pwdata[VALUE_BITS-1:0];
            REG_STEP_SIZE:     cfg_ff.step_size     <= pwdata[COUNT_BITS-1:0];
            REG_LOCKOUT_TICKS: cfg_ff.lockout_ticks <= pwdata[COUNT_BITS-1:0];
            REG_REPEAT_TICKS:  cfg_ff.repeat_ticks  <= pwdata[COUNT_BITS-1:0];
            REG_TIMEOUT_SECS:  cfg_ff.timeout_secs  <= pwdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         REG_MAX_VALUE:     prdata = CSR_DATA_BITS'(max_value_ff);
         REG_STEP_SIZE:     prdata = CSR_DATA_BITS'(cfg_ff.step_size);
         REG_LOCKOUT_TICKS: prdata = CSR_DATA_BITS'(cfg_ff.lockout_ticks);
         REG_REPEAT_TICKS:  prdata = CSR_DATA_BITS'(cfg_ff.repeat_ticks);
         REG_TIMEOUT_SECS:  prdata = CSR_DATA_BITS'(cfg_ff.timeout_secs);
         default:           prdata = '0;
      endcase
   end

   assign max_value = max_value_ff;
   assign cfg       = cfg_ff;

endmodule

>>> design/skc_core.sv
// Channel state registers and the combinational event update.
module skc_core
   import skc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  op_type                op,
   input  logic                  power_key,
   input  logic                  plus_key,
   input  logic                  minus_key,
   input  logic                  attached,
   input  logic [VALUE_BITS-1:0] restore_value,
   input  logic [VALUE_BITS-1:0] max_value,
   input  cfg_type               cfg,
   output logic                  power_on,
   output mode_type              mode,
   output logic [VALUE_BITS-1:0] target,
   output logic [VALUE_BITS-1:0] edit_value,
   output logic                  save_request,
   output beep_type              beep
);

   localparam int SUM_BITS = ((VALUE_BITS > COUNT_BITS) ? VALUE_BITS : COUNT_BITS) + 1;

   logic                  on_ff, on_in;
   mode_type              mode_ff, mode_in;
   logic [VALUE_BITS-1:0] target_ff, target_in;
   logic [VALUE_BITS-1:0] edit_ff, edit_in;
   logic [COUNT_BITS-1:0] lockout_ff, lockout_in;
   logic [COUNT_BITS-1:0] repeat_ff, repeat_in;
   logic [COUNT_BITS-1:0] timeout_ff, timeout_in;
   logic                  do_commit;
   logic                  save;
   beep_type              beep_code;
   logic [SUM_BITS-1:0]   edit_wide;
   logic [SUM_BITS-1:0]   step_wide;
   logic [SUM_BITS-1:0]   plus_sum;
   logic                  plus_fits;

   assign edit_wide = SUM_BITS'(edit_ff);
   assign step_wide = SUM_BITS'(cfg.step_size);
   assign plus_sum  = edit_wide + step_wide;
   assign plus_fits = plus_sum <= SUM_BITS'(max_value);

   always_comb begin
      on_in      = on_ff;
      mode_in    = mode_ff;
      target_in  = target_ff;
      edit_in    = edit_ff;
      lockout_in = lockout_ff;
      repeat_in  = repeat_ff;
      timeout_in = timeout_ff;
      do_commit  = 1'b0;
      save       = 1'b0;
      beep_code  = BEEP_NONE;

      case (op)
         OP_KEY_SCAN: begin
            // reload a running lockout while power is held, else run it down
            if (lockout_ff != '0) begin
               lockout_in = power_key ? cfg.lockout_ticks : lockout_ff - 1'b1;
            end
            if (power_key) begin
               if (!on_ff && lockout_in == '0 && mode_ff != MODE_NODEV) begin
                  on_in      = 1'b1;
                  do_commit  = 1'b1;
                  lockout_in = cfg.lockout_ticks;
                  beep_code  = BEEP_TRIPLE;
               end
            end else if (plus_key || minus_key) begin
               beep_code  = BEEP_SHORT;
               timeout_in = cfg.timeout_secs;
               if (mode_ff == MODE_NORMAL) begin
                  edit_in   = target_ff;
                  mode_in   = MODE_SET;
                  repeat_in = cfg.repeat_ticks;
               end else if (mode_ff == MODE_SET && repeat_ff == '0) begin
                  // plus wins when it fits; minus stops at zero
                  if (plus_key && plus_fits) begin
                     edit_in = plus_sum[VALUE_BITS-1:0];
                  end else if (minus_key && edit_ff != '0) begin
                     edit_in = (edit_wide > step_wide) ?
                               edit_ff - VALUE_BITS'(step_wide) : '0;
                  end
                  repeat_in = cfg.repeat_ticks;
               end
            end else begin
               repeat_in = '0;
            end
         end
         OP_SECOND_TICK: begin
            if (timeout_ff != '0) begin
               timeout_in = timeout_ff - 1'b1;
               if (timeout_in == '0) begin
                  do_commit = 1'b1;
                  beep_code = BEEP_SHORT;
               end
            end
         end
         OP_REPEAT_TICK: begin
            if (repeat_ff != '0) begin
               repeat_in = repeat_ff - 1'b1;
            end
         end
         OP_OFF_REQUEST: begin
            if (on_ff) begin
               on_in      = 1'b0;
               do_commit  = 1'b1;
               lockout_in = cfg.lockout_ticks;
               beep_code  = BEEP_TRIPLE;
            end
         end
         OP_ATTACH: begin
            // drop any edit in progress when the device goes away
            if (!attached) begin
               mode_in = MODE_NODEV;
            end else if (mode_ff == MODE_NODEV) begin
               mode_in = MODE_NORMAL;
            end
         end
         OP_RESTORE: begin
            target_in = restore_value;
         end
         default: ;
      endcase

      if (do_commit) begin
         if (mode_ff == MODE_SET) begin
            target_in = edit_ff;
            save      = 1'b1;
         end
         if (mode_ff != MODE_NODEV) begin
            mode_in = MODE_NORMAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff      <= 1'b0;
         mode_ff    <= MODE_NORMAL;
         target_ff  <= '0;
         edit_ff    <= '0;
         lockout_ff <= COUNT_BITS'(LOCKOUT_TICKS_RESET);
         repeat_ff  <= COUNT_BITS'(REPEAT_TICKS_RESET);
         timeout_ff <= '0;
      end else if (advance) begin
         on_ff      <= on_in;
         mode_ff    <= mode_in;
         target_ff  <= target_in;
         edit_ff    <= edit_in;
         lockout_ff <= lockout_in;
         repeat_ff  <= repeat_in;
         timeout_ff <= timeout_in;
      end
   end

   assign power_on     = on_in;
   assign mode         = mode_in;
   assign target       = target_in;
   assign edit_value   = edit_in;
   assign save_request = save;
   assign beep         = beep_code;

endmodule
